// ----- hdl/kra_pkg.sv -----
// Shared types, widths, reset values and codes for the key repeat accelerator.
package kra_pkg;

	localparam int FT_W     = 16;   // frame time, Q0.16
	localparam int THR_W    = 32;   // repeat threshold and travel, Q16.16
	localparam int RATE_W   = 24;   // speed, Q16.8
	localparam int ACC_W    = 12;   // acceleration, Q4.8
	localparam int ACT_W    = 3;
	localparam int IDX_W    = 2;
	localparam int DATA_W   = 32;
	localparam int FRAC_SH  = 8;    // Q.8 scaling of rate and acceleration
	localparam int PROD_W   = RATE_W + FT_W;
	localparam int INC_W    = PROD_W + 2 - FRAC_SH;
	localparam int NKEYS    = 7;    // six repeat keys and pause
	localparam int NREP     = 6;
	localparam int KEY_W    = 3;

	localparam logic [THR_W-1:0]  THR_RST   = 32'd1310720;
	localparam logic [RATE_W-1:0] SPEED_RST = 24'd15360;
	localparam logic [ACC_W-1:0]  ACCEL_RST = 12'd435;

	localparam logic [IDX_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [IDX_W-1:0] REG_SPEED     = 2'd1;
	localparam logic [IDX_W-1:0] REG_ACCEL     = 2'd2;

	localparam logic [ACT_W-1:0] ACT_RIGHT   = 3'd0;
	localparam logic [ACT_W-1:0] ACT_LEFT    = 3'd1;
	localparam logic [ACT_W-1:0] ACT_ROT_CW  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_ROT_CCW = 3'd3;
	localparam logic [ACT_W-1:0] ACT_DROP    = 3'd4;
	localparam logic [ACT_W-1:0] ACT_PAUSE   = 3'd5;

	localparam logic [KEY_W-1:0] KEY_RIGHT = 3'd0;
	localparam logic [KEY_W-1:0] KEY_LEFT  = 3'd1;
	localparam logic [KEY_W-1:0] KEY_UP    = 3'd2;
	localparam logic [KEY_W-1:0] KEY_Z     = 3'd3;
	localparam logic [KEY_W-1:0] KEY_X     = 3'd4;
	localparam logic [KEY_W-1:0] KEY_DOWN  = 3'd5;
	localparam logic [KEY_W-1:0] KEY_PAUSE = 3'd6;

	typedef struct packed {
		logic [THR_W-1:0]  threshold;
		logic [RATE_W-1:0] init_speed;
		logic [ACC_W-1:0]  accel;
	} cfg_t;

	// one request from the sequencer to the output stage
	typedef struct packed {
		logic             fire;    // new action, not yet known to be the last
		logic             flush;   // frame done: release the held action as last
		logic [ACT_W-1:0] action;
	} evt_t;

	function automatic logic [ACT_W-1:0] key_action(input logic [KEY_W-1:0] k);
		logic [ACT_W-1:0] a;
		unique case (k)
			KEY_RIGHT: a = ACT_RIGHT;
			KEY_LEFT:  a = ACT_LEFT;
			KEY_UP:    a = ACT_ROT_CW;
			KEY_Z:     a = ACT_ROT_CCW;
			KEY_X:     a = ACT_ROT_CW;
			KEY_DOWN:  a = ACT_DROP;
			default:   a = ACT_PAUSE;
		endcase
		return a;
	endfunction

endpackage

// ----- hdl/kra_if.sv -----
// Channel interfaces: frame input, action output and register writes.
interface kra_in_if;
	logic                      valid;
	logic                      ready;
	logic [kra_pkg::FT_W-1:0]  frame_time;
	logic                      key_right;
	logic                      key_left;
	logic                      key_up;
	logic                      key_z;
	logic                      key_x;
	logic                      key_down;
	logic                      key_pause;

	modport source (output valid, frame_time, key_right, key_left, key_up, key_z, key_x,
		key_down, key_pause, input ready);
	modport sink (input valid, frame_time, key_right, key_left, key_up, key_z, key_x,
		key_down, key_pause, output ready);
endinterface

interface kra_out_if;
	logic                      valid;
	logic                      ready;
	logic [kra_pkg::ACT_W-1:0] action;
	logic                      last;

	modport source (output valid, action, last, input ready);
	modport sink (input valid, action, last, output ready);
endinterface

interface kra_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [kra_pkg::IDX_W-1:0]  index;
	logic [kra_pkg::DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/key_repeat_accelerator_unit.sv -----
// Key auto-repeat with acceleration: one frame in, zero to seven actions out.
//
// Channels: keys takes one frame word (frame time in Q0.16 and seven key levels);
// acts gives one action word per fired action, in key order right, left, up,
// z, x, down, pause, with last set on the final word of the frame. A frame
// that fires nothing gives no word. cfg writes threshold (index 0), initial
// speed (index 1) and acceleration (index 2); it is always ready.
// A frame takes longer for each pressed repeat key and each repeat that
// accelerates, and longer still while acts stalls. Most of that time goes to the
// bit-serial multiplier, which works bit by bit, MSB first, on each rate times
// frame-time product and again on each rate times acceleration.
// keys is ready only between frames; the final action of a frame leaves the
// block once the frame word has been fully worked through.
// Reset clears the held flags, pause flag and travel, loads rate with the
// default initial speed and restores the default registers.
// When acts stalls, one action waits in the output register and one more in
// the hold stage; the sequencer then halts on its next fire until the output register frees.
module key_repeat_accelerator_unit (
	input  logic      clk,
	input  logic      arst_n,
	kra_in_if.sink    keys,
	kra_out_if.source acts,
	kra_cfg_if.sink   cfg
);

	localparam int ST_W = 4;
	localparam logic [ST_W-1:0] S_IDLE   = 4'd0;
	localparam logic [ST_W-1:0] S_KEY    = 4'd1;
	localparam logic [ST_W-1:0] S_MUL    = 4'd2;
	localparam logic [ST_W-1:0] S_TRIPLE = 4'd3;
	localparam logic [ST_W-1:0] S_ADD    = 4'd4;
	localparam logic [ST_W-1:0] S_CMP    = 4'd5;
	localparam logic [ST_W-1:0] S_ACC    = 4'd6;
	localparam logic [ST_W-1:0] S_FIRE   = 4'd7;
	localparam logic [ST_W-1:0] S_PAUSE  = 4'd8;
	localparam logic [ST_W-1:0] S_FLUSH  = 4'd9;

	localparam int THR_W  = kra_pkg::THR_W;
	localparam int RATE_W = kra_pkg::RATE_W;
	localparam int PROD_W = kra_pkg::PROD_W;
	localparam int INC_W  = kra_pkg::INC_W;
	localparam int SH     = kra_pkg::FRAC_SH;

	kra_pkg::cfg_t regs;
	kra_pkg::evt_t ev;
	logic          out_rdy;

	logic [ST_W-1:0]           state_q;
	logic [kra_pkg::KEY_W-1:0] key_q;
	logic [kra_pkg::FT_W-1:0]  ft_q;
	logic [kra_pkg::NKEYS-1:0] lvl_q;
	logic [kra_pkg::NREP-1:0]  held_q;
	logic                      pause_held_q;
	logic [THR_W-1:0]          travel_q;
	logic [RATE_W-1:0]         rate_q;
	logic [INC_W-1:0]          inc_q;

	logic                      mul_start;
	logic [kra_pkg::FT_W-1:0]  mul_b;
	logic                      mul_done;
	logic [PROD_W-1:0]         mul_p;

	logic                      lvl_k;
	logic                      held_k;
	logic                      is_drop;
	logic [PROD_W+1:0]         prod3;
	logic [THR_W+2:0]          sum;
	logic [THR_W:0]            diff;
	logic                      over;
	logic                      pause_edge;
	logic [RATE_W-1:0]         rate_acc;

	kra_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	kra_ser_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (rate_q),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	kra_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.ev     (ev),
		.rdy    (out_rdy),
		.acts   (acts)
	);

	assign keys.ready = (state_q == S_IDLE);

	assign lvl_k      = lvl_q[key_q];
	assign held_k     = held_q[key_q];
	assign is_drop    = (key_q == kra_pkg::KEY_DOWN);
	assign pause_edge = lvl_q[kra_pkg::KEY_PAUSE] && !pause_held_q;

	// soft drop moves three times as far: p + 2p
	assign prod3 = {1'b0, mul_p, 1'b0} + {2'b00, mul_p};
	assign sum   = {3'b000, travel_q} + (THR_W+3)'(inc_q);
	assign diff  = {1'b0, travel_q} - {1'b0, regs.threshold};
	assign over  = !diff[THR_W] && (diff[THR_W-1:0] != '0);

	// rate * acceleration >> 8, clamped to the rate width
	assign rate_acc = (mul_p[PROD_W-1:RATE_W+SH] != '0) ? '1 : mul_p[RATE_W+SH-1:SH];

	// start the frame-time product from a pressed key, the acceleration product
	// from a repeat of any key but soft drop
	assign mul_start = ((state_q == S_KEY) && lvl_k)
		|| ((state_q == S_CMP) && over && !is_drop);
	assign mul_b     = (state_q == S_KEY) ? ft_q : kra_pkg::FT_W'(regs.accel);

	always_comb begin
		ev.fire   = 1'b0;
		ev.flush  = 1'b0;
		ev.action = kra_pkg::key_action(key_q);
		unique case (state_q)
			S_FIRE:  ev.fire = out_rdy;
			S_PAUSE: begin
				ev.fire   = pause_edge && out_rdy;
				ev.action = kra_pkg::ACT_PAUSE;
			end
			S_FLUSH: ev.flush = out_rdy;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			key_q        <= '0;
			ft_q         <= '0;
			lvl_q        <= '0;
			held_q       <= '0;
			pause_held_q <= 1'b0;
			travel_q     <= '0;
			rate_q       <= kra_pkg::SPEED_RST;
			inc_q        <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (keys.valid) begin
						ft_q    <= keys.frame_time;
						lvl_q   <= {keys.key_pause, keys.key_down, keys.key_x, keys.key_z,
							keys.key_up, keys.key_left, keys.key_right};
						key_q   <= kra_pkg::KEY_RIGHT;
						state_q <= S_KEY;
					end
				end
				S_KEY: begin
					if (lvl_k) begin
						state_q <= S_MUL;
					end else begin
						// release: drop the held flag, clear travel, reload speed
						if (held_k) begin
							held_q[key_q] <= 1'b0;
							travel_q      <= '0;
							rate_q        <= regs.init_speed;
						end
						if (key_q == kra_pkg::KEY_DOWN) begin
							state_q <= S_PAUSE;
						end else begin
							key_q <= key_q + 1'b1;
						end
					end
				end
				S_MUL: begin
					if (mul_done) begin
						state_q <= S_TRIPLE;
					end
				end
				S_TRIPLE: begin
					inc_q   <= is_drop ? prod3[PROD_W+1:SH] : INC_W'(mul_p[PROD_W-1:SH]);
					state_q <= S_ADD;
				end
				S_ADD: begin
					travel_q <= (sum[THR_W+2:THR_W] != '0) ? '1 : sum[THR_W-1:0];
					if (!held_k) begin
						held_q[key_q] <= 1'b1;
						state_q       <= S_FIRE;
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (over) begin
						travel_q <= diff[THR_W-1:0];
						state_q  <= is_drop ? S_FIRE : S_ACC;
					end else if (key_q == kra_pkg::KEY_DOWN) begin
						state_q <= S_PAUSE;
					end else begin
						key_q   <= key_q + 1'b1;
						state_q <= S_KEY;
					end
				end
				S_ACC: begin
					if (mul_done) begin
						rate_q  <= rate_acc;
						state_q <= S_FIRE;
					end
				end
				S_FIRE: begin
					if (out_rdy) begin
						if (key_q == kra_pkg::KEY_DOWN) begin
							state_q <= S_PAUSE;
						end else begin
							key_q   <= key_q + 1'b1;
							state_q <= S_KEY;
						end
					end
				end
				S_PAUSE: begin
					// toggle on the press edge only; hold until the word is taken
					if (pause_edge) begin
						if (out_rdy) begin
							pause_held_q <= 1'b1;
							state_q      <= S_FLUSH;
						end
					end else begin
						if (!lvl_q[kra_pkg::KEY_PAUSE]) begin
							pause_held_q <= 1'b0;
						end
						state_q <= S_FLUSH;
					end
				end
				S_FLUSH: begin
					if (out_rdy) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- hdl/kra_cfg_regs.sv -----
// Configuration register file: threshold, initial speed and acceleration.
module kra_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	kra_cfg_if.sink       cfg,
	output kra_pkg::cfg_t regs
);

	kra_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.threshold  <= kra_pkg::THR_RST;
			regs_q.init_speed <= kra_pkg::SPEED_RST;
			regs_q.accel      <= kra_pkg::ACCEL_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				kra_pkg::REG_THRESHOLD: regs_q.threshold  <= cfg.data[kra_pkg::THR_W-1:0];
				kra_pkg::REG_SPEED:     regs_q.init_speed <= cfg.data[kra_pkg::RATE_W-1:0];
				kra_pkg::REG_ACCEL:     regs_q.accel      <= cfg.data[kra_pkg::ACC_W-1:0];
				default: ;  // drop writes beyond the register list
			endcase
		end
	end

endmodule

// ----- hdl/kra_ser_mul.sv -----
// Bit-serial shift-add multiplier, one multiplier bit per cycle, MSB first.
module kra_ser_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [kra_pkg::RATE_W-1:0]    a,
	input  logic [kra_pkg::FT_W-1:0]      b,
	output logic                          done,
	output logic [kra_pkg::PROD_W-1:0]    p
);

	localparam int CNT_W = $clog2(kra_pkg::FT_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(kra_pkg::FT_W - 1);

	logic                        busy_q;
	logic                        done_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [kra_pkg::RATE_W-1:0]  a_q;
	logic [kra_pkg::FT_W-1:0]    b_q;
	logic [kra_pkg::PROD_W-1:0]  acc_q;
	logic [kra_pkg::PROD_W-1:0]  addend;

	assign addend = b_q[kra_pkg::FT_W-1] ? kra_pkg::PROD_W'(a_q) : '0;
	assign done   = done_q;
	assign p      = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			a_q    <= '0;
			b_q    <= '0;
			acc_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				a_q    <= a;
				b_q    <= b;
				acc_q  <= '0;
			end else if (busy_q) begin
				// double, then add the multiplicand when the next bit is set
				acc_q <= {acc_q[kra_pkg::PROD_W-2:0], 1'b0} + addend;
				b_q   <= {b_q[kra_pkg::FT_W-2:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ----- hdl/kra_out_stage.sv -----
// Output stage: hold the newest action until it is known whether it ends the frame.
module kra_out_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  kra_pkg::evt_t ev,
	output logic          rdy,
	kra_out_if.source     acts
);

	logic                      pend_valid_q;
	logic [kra_pkg::ACT_W-1:0] pend_act_q;
	logic                      out_valid_q;
	logic [kra_pkg::ACT_W-1:0] out_act_q;
	logic                      out_last_q;
	logic                      can_load;
	logic                      push;

	assign can_load = !out_valid_q || acts.ready;
	assign rdy      = !pend_valid_q || can_load;
	assign push     = pend_valid_q && (ev.fire || ev.flush) && can_load;

	assign acts.valid  = out_valid_q;
	assign acts.action = out_act_q;
	assign acts.last   = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			pend_act_q   <= '0;
			out_valid_q  <= 1'b0;
			out_act_q    <= '0;
			out_last_q   <= 1'b0;
		end else begin
			if (push) begin
				out_valid_q <= 1'b1;
				out_act_q   <= pend_act_q;
				out_last_q  <= ev.flush;
			end else if (acts.ready) begin
				out_valid_q <= 1'b0;
			end
			if (ev.fire && rdy) begin
				pend_valid_q <= 1'b1;
				pend_act_q   <= ev.action;
			end else if (ev.flush && rdy) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

endmodule
